@@ src/tws_pkg.sv @@
// Shared constants and types for the time window statistics block.
package tws_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned STAMP_W      = 63;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned SUM_W        = 40;
  localparam int unsigned SQ_W         = 56;
  localparam logic [STAMP_W-1:0] HORIZON_RESET = 63'd1000000000;

  // shared unit operations
  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ src/tws_ram.sv @@
// Generic single write, single read RAM with registered read data.
module tws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/tws_divsqrt.sv @@
// Shared iterative unit: unsigned 64 by CW bit divide, or 64 bit integer square root.
module tws_divsqrt #(
  parameter int unsigned CW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tws_pkg::unit_ctrl_t ctrl_i,
  input  logic [63:0]         a_i,
  input  logic [CW-1:0]       d_i,
  output tws_pkg::unit_sts_t  sts_o,
  output logic [63:0]         q_o
);

  logic        op_q;
  logic [6:0]  cnt_q;
  logic        done_q;
  logic [63:0] acc_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [CW-1:0] d_q;

  logic [33:0] r_div, r_sq, trial;
  logic        ge_div, ge_sq;

  always_comb begin
    r_div  = {rem_q[32:0], acc_q[63]};
    ge_div = r_div >= 34'(d_q);
    r_sq   = {rem_q[31:0], acc_q[63:62]};
    trial  = {root_q, 2'b01};
    ge_sq  = r_sq >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      op_q   <= tws_pkg::OP_DIV;
    end else begin
      done_q <= (cnt_q == 7'd1);
      if (ctrl_i.start) begin
        op_q  <= ctrl_i.op;
        cnt_q <= (ctrl_i.op == tws_pkg::OP_SQRT) ? 7'd32 : 7'd64;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q  <= a_i;
      d_q    <= d_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      if (op_q == tws_pkg::OP_SQRT) begin
        acc_q  <= {acc_q[61:0], 2'b00};
        rem_q  <= ge_sq ? (r_sq - trial) : r_sq;
        root_q <= {root_q[30:0], ge_sq};
      end else begin
        acc_q <= {acc_q[62:0], ge_div};
        rem_q <= ge_div ? (r_div - 34'(d_q)) : r_div;
      end
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;
  assign q_o = (op_q == tws_pkg::OP_SQRT) ? {32'd0, root_q} : acc_q;

endmodule

@@ src/time_window_statistics.sv @@
// Top level: sliding time window with min, max, mean and sample deviation.
// Per word: each drop (forced or stale) scans the held entries, the insert shifts entries up,
// each stale check reads the front stamp, then min/max and the mean divide run, plus the
// deviation when two or more entries remain, then the result is written out.
// One word in flight, taken only when idle; a stalled output holds the sequencer in S_OUT.
// Reset (async, active low) empties the window and loads horizon with 1e9 ns; no clearing pass.
module time_window_statistics #(
  parameter int unsigned CAPACITY = tws_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // horizon register
  input  logic                                cfg_we_i,
  input  logic [tws_pkg::STAMP_W-1:0]         cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tws_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [tws_pkg::STAMP_W-1:0]         stamp_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [$clog2(CAPACITY+1)-1:0]       count_o,
  output logic signed [tws_pkg::SAMPLE_W-1:0] oldest_o,
  output logic signed [tws_pkg::SAMPLE_W-1:0] newest_o,
  output logic signed [tws_pkg::SAMPLE_W-1:0] minimum_o,
  output logic signed [tws_pkg::SAMPLE_W-1:0] maximum_o,
  output logic signed [tws_pkg::SAMPLE_W-1:0] mean_o,
  output logic [31:0]                         deviation_o,
  output logic                                deviation_valid_o,
  output logic                                forced_evict_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam int unsigned SW = tws_pkg::STAMP_W;
  localparam int unsigned XW = tws_pkg::SAMPLE_W;
  localparam int unsigned SUM_W = tws_pkg::SUM_W;
  localparam int unsigned SQ_W  = tws_pkg::SQ_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DRD   = 5'd1;   // read oldest sample
  localparam logic [4:0] S_DX    = 5'd2;
  localparam logic [4:0] S_ERD   = 5'd3;   // erase scan, read
  localparam logic [4:0] S_ECHK  = 5'd4;   // erase scan, compare / shift down
  localparam logic [4:0] S_DMUL  = 5'd5;
  localparam logic [4:0] S_DUPD  = 5'd6;
  localparam logic [4:0] S_PWR   = 5'd7;   // write rings
  localparam logic [4:0] S_IRD   = 5'd8;   // insert scan, read
  localparam logic [4:0] S_ICHK  = 5'd9;   // insert scan, compare / shift up
  localparam logic [4:0] S_PMUL  = 5'd10;
  localparam logic [4:0] S_PUPD  = 5'd11;
  localparam logic [4:0] S_VRD   = 5'd12;  // stale check, read front stamp
  localparam logic [4:0] S_VCHK  = 5'd13;
  localparam logic [4:0] S_RMIN  = 5'd14;
  localparam logic [4:0] S_RMAX  = 5'd15;
  localparam logic [4:0] S_MEAN  = 5'd16;
  localparam logic [4:0] S_MEANW = 5'd17;
  localparam logic [4:0] S_C0    = 5'd18;  // S*S in three partial products
  localparam logic [4:0] S_C1    = 5'd19;
  localparam logic [4:0] S_C2    = 5'd20;
  localparam logic [4:0] S_C3    = 5'd21;
  localparam logic [4:0] S_CW    = 5'd22;  // wait corr = S*S/n
  localparam logic [4:0] S_VW    = 5'd23;  // wait var = diff/(n-1)
  localparam logic [4:0] S_SW    = 5'd24;  // wait root
  localparam logic [4:0] S_OUT   = 5'd25;

  logic [4:0] state_q, state_d;

  // window control
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;       // scan index, erase and insert share it
  logic          found_q, found_d;
  logic          stale_q, stale_d;   // drop belongs to the stale walk
  logic [SW-1:0] horizon_q;
  logic          out_valid_q;

  // working data
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic signed [XW-1:0]    xin_q, op_x_q;
  logic [SW-1:0]           t_q;
  logic                    forced_q;
  logic signed [XW-1:0]    min_q, max_q, old_q, mean_q;
  logic [31:0]             dev_q;
  logic                    dvalid_q;
  logic [63:0]             corr_q;
  logic [63:0]             mul_q;
  logic [31:0]             mul_a, mul_b;

  // memories
  logic          smp_we, stp_we, srt_we;
  logic [AW-1:0] smp_raddr, stp_raddr, srt_raddr, srt_waddr;
  logic [XW-1:0] smp_rdata, srt_rdata, srt_wdata;
  logic [SW-1:0] stp_rdata;

  // shared divide / root unit
  tws_pkg::unit_ctrl_t unit_ctrl;
  tws_pkg::unit_sts_t  unit_sts;
  logic [63:0]         unit_a, unit_q;
  logic [CW-1:0]       unit_d;

  logic [SUM_W-1:0] abs_sum;
  logic [XW-1:0]    abs_x;
  logic [CW-1:0]    idx_m1, fill_m1;
  logic [AW-1:0]    head_inc, tail_inc;
  logic [63:0]      diff;
  logic [47:0]      var_sat;
  logic             stale_hit;
  logic             out_free;

  assign abs_sum  = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign abs_x    = op_x_q[XW-1] ? (~op_x_q + XW'(1)) : op_x_q;
  assign idx_m1   = idx_q - CW'(1);
  assign fill_m1  = fill_q - CW'(1);
  assign head_inc = (head_q == AW'(CAPACITY-1)) ? '0 : head_q + AW'(1);
  assign tail_inc = (tail_q == AW'(CAPACITY-1)) ? '0 : tail_q + AW'(1);
  // unit_q holds corr = floor(S*S / 2^16) / n once the unit reports done in S_CW
  assign diff     = ({8'd0, sq_q} > unit_q) ? ({8'd0, sq_q} - unit_q) : 64'd0;
  assign var_sat  = (unit_q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : unit_q[47:0];
  // no wrap: 64 bit sum of two 63 bit values
  assign stale_hit = ({1'b0, stp_rdata} + {1'b0, horizon_q}) < {1'b0, t_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  // single 32x32 multiplier, registered
  always_comb begin
    mul_a = abs_x;
    mul_b = abs_x;
    unique case (state_q)
      S_C0: begin
        mul_a = 32'(abs_sum[39:20]);
        mul_b = 32'(abs_sum[39:20]);
      end
      S_C1: begin
        mul_a = 32'(abs_sum[39:20]);
        mul_b = 32'(abs_sum[19:0]);
      end
      S_C2: begin
        mul_a = 32'(abs_sum[19:0]);
        mul_b = 32'(abs_sum[19:0]);
      end
      default: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    found_d   = found_q;
    stale_d   = stale_q;
    sum_d     = sum_q;
    sq_d      = sq_q;
    smp_we    = 1'b0;
    stp_we    = 1'b0;
    srt_we    = 1'b0;
    smp_raddr = head_q;
    stp_raddr = head_q;
    srt_raddr = idx_q[AW-1:0];
    srt_waddr = idx_q[AW-1:0];
    srt_wdata = op_x_q;
    unit_ctrl = '{start: 1'b0, op: tws_pkg::OP_DIV};
    unit_a    = 64'(abs_sum);
    unit_d    = fill_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          stale_d = 1'b0;
          state_d = (fill_q == CW'(CAPACITY)) ? S_DRD : S_PWR;
        end
      end
      S_DRD: state_d = S_DX;
      S_DX: begin
        idx_d   = '0;
        found_d = 1'b0;
        state_d = S_ERD;
      end
      S_ERD: begin
        state_d = (idx_q == fill_q) ? S_DMUL : S_ECHK;
      end
      S_ECHK: begin
        // after the first match every entry moves down one place
        if (found_q) begin
          srt_we    = 1'b1;
          srt_waddr = idx_m1[AW-1:0];
          srt_wdata = srt_rdata;
        end else if ($signed(srt_rdata) == op_x_q) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_ERD;
      end
      S_DMUL: state_d = S_DUPD;
      S_DUPD: begin
        sum_d   = sum_q - SUM_W'(op_x_q);
        sq_d    = sq_q - SQ_W'(mul_q[63:16]);
        head_d  = head_inc;
        fill_d  = fill_m1;
        state_d = stale_q ? S_VRD : S_PWR;
      end
      S_PWR: begin
        smp_we  = 1'b1;
        stp_we  = 1'b1;
        tail_d  = tail_inc;
        idx_d   = fill_q;
        state_d = S_IRD;
      end
      S_IRD: begin
        srt_raddr = idx_m1[AW-1:0];
        if (idx_q == '0) begin
          srt_we  = 1'b1;
          state_d = S_PMUL;
        end else begin
          state_d = S_ICHK;
        end
      end
      S_ICHK: begin
        srt_we = 1'b1;
        if ($signed(srt_rdata) > op_x_q) begin
          srt_wdata = srt_rdata;
          idx_d     = idx_m1;
          state_d   = S_IRD;
        end else begin
          state_d = S_PMUL;
        end
      end
      S_PMUL: state_d = S_PUPD;
      S_PUPD: begin
        sum_d   = sum_q + SUM_W'(op_x_q);
        sq_d    = sq_q + SQ_W'(mul_q[63:16]);
        fill_d  = fill_q + CW'(1);
        stale_d = 1'b1;
        state_d = S_VRD;
      end
      S_VRD: state_d = S_VCHK;
      S_VCHK: state_d = stale_hit ? S_DRD : S_RMIN;
      S_RMIN: begin
        srt_raddr = '0;
        state_d   = S_RMAX;
      end
      S_RMAX: begin
        srt_raddr = fill_m1[AW-1:0];
        state_d   = S_MEAN;
      end
      S_MEAN: begin
        unit_ctrl = '{start: 1'b1, op: tws_pkg::OP_DIV};
        state_d   = S_MEANW;
      end
      S_MEANW: begin
        if (unit_sts.done) begin
          state_d = (fill_q < CW'(2)) ? S_OUT : S_C0;
        end
      end
      S_C0: state_d = S_C1;
      S_C1: state_d = S_C2;
      S_C2: state_d = S_C3;
      S_C3: state_d = S_CW;
      S_CW: begin
        if (unit_sts.done) begin
          unit_ctrl = '{start: 1'b1, op: tws_pkg::OP_DIV};
          unit_a    = diff;
          unit_d    = fill_m1;
          state_d   = S_VW;
        end
      end
      S_VW: begin
        if (unit_sts.done) begin
          unit_ctrl = '{start: 1'b1, op: tws_pkg::OP_SQRT};
          unit_a    = {var_sat, 16'd0};
          state_d   = S_SW;
        end
      end
      S_SW: begin
        if (unit_sts.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // corr = S*S/n starts once the last partial product is in
    if (state_q == S_C3) begin
      unit_ctrl = '{start: 1'b1, op: tws_pkg::OP_DIV};
      unit_a    = corr_q + (mul_q >> 16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      stale_q     <= 1'b0;
      sum_q       <= '0;
      sq_q        <= '0;
      horizon_q   <= tws_pkg::HORIZON_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      stale_q <= stale_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      if (cfg_we_i) begin
        horizon_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      xin_q    <= sample_i;
      t_q      <= stamp_i;
      forced_q <= (fill_q == CW'(CAPACITY));
    end
    if (state_q == S_DX) begin
      op_x_q <= $signed(smp_rdata);
    end
    if (state_q == S_PWR) begin
      op_x_q <= xin_q;
    end
    if (state_q == S_RMAX) begin
      min_q <= $signed(srt_rdata);
      old_q <= $signed(smp_rdata);
    end
    if (state_q == S_MEAN) begin
      max_q <= $signed(srt_rdata);
    end
    if (state_q == S_MEANW && unit_sts.done) begin
      mean_q   <= sum_q[SUM_W-1] ? $signed(~unit_q[31:0] + 32'd1) : $signed(unit_q[31:0]);
      dev_q    <= '0;
      dvalid_q <= 1'b0;
    end
    if (state_q == S_C1) begin
      corr_q <= mul_q << 24;
    end
    if (state_q == S_C2) begin
      corr_q <= corr_q + (mul_q << 5);
    end
    if (state_q == S_SW && unit_sts.done) begin
      dev_q    <= unit_q[31:0];
      dvalid_q <= 1'b1;
    end
    if (state_q == S_OUT && out_free) begin
      count_o           <= fill_q;
      oldest_o          <= old_q;
      newest_o          <= xin_q;
      minimum_o         <= min_q;
      maximum_o         <= max_q;
      mean_o            <= mean_q;
      deviation_o       <= dev_q;
      deviation_valid_o <= dvalid_q;
      forced_evict_o    <= forced_q;
    end
  end

  assign out_valid_o = out_valid_q;

  tws_ram #(.WIDTH(XW), .DEPTH(CAPACITY)) u_sample_ring (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (tail_q),
    .wdata_i (xin_q),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  tws_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stamp_ring (
    .clk_i   (clk_i),
    .we_i    (stp_we),
    .waddr_i (tail_q),
    .wdata_i (t_q),
    .raddr_i (stp_raddr),
    .rdata_o (stp_rdata)
  );

  tws_ram #(.WIDTH(XW), .DEPTH(CAPACITY)) u_sorted_store (
    .clk_i   (clk_i),
    .we_i    (srt_we),
    .waddr_i (srt_waddr),
    .wdata_i (srt_wdata),
    .raddr_i (srt_raddr),
    .rdata_o (srt_rdata)
  );

  tws_divsqrt #(.CW(CW)) u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (unit_ctrl),
    .a_i    (unit_a),
    .d_i    (unit_d),
    .sts_o  (unit_sts),
    .q_o    (unit_q)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY)) else $error("window fill above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE)) else $error("word accepted but idle");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o != '0)) else $error("empty window reported");

  a_dev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !deviation_valid_o) |-> (deviation_o == '0))
    else $error("deviation not zero while invalid");

  a_dev_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && deviation_valid_o) |-> (count_o >= 2))
    else $error("deviation valid with fewer than two entries");

endmodule
